// ----- src/button_press_classifier_menu_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the button press classifier
// Shared property wrappers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_MENU_UNIT_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_MENU_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BPCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bpcm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpcm_pkg
// Types and constants shared by the button press classifier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpcm_pkg;

  localparam int unsigned TimerW   = 16;
  localparam int unsigned BlinkW   = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [TimerW-1:0] TimerMax = '1;
  localparam logic [BlinkW-1:0] BlinkMax = '1;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegShortMin  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLongMin   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLongMax   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHold      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNetBlink  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDevBlink  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInitNet   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegInitDev   = 3'd7;

  // register reset values
  localparam logic [CfgW-1:0] ShortMinRst = 16'd100;
  localparam logic [CfgW-1:0] LongMinRst  = 16'd700;
  localparam logic [CfgW-1:0] LongMaxRst  = 16'd1500;
  localparam logic [CfgW-1:0] HoldRst     = 16'd3000;
  localparam logic [CfgW-1:0] NetBlinkRst = 16'd200;
  localparam logic [CfgW-1:0] DevBlinkRst = 16'd600;

  // mode codes as seen on the result beat
  localparam logic [1:0] ModeCodeIdle    = 2'd0;
  localparam logic [1:0] ModeCodeSetting = 2'd1;
  localparam logic [1:0] ModeCodeRun     = 2'd2;

  // edit field codes
  localparam logic FieldNetwork = 1'b0;
  localparam logic FieldDevice  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_SETTING = 3'b010,
    MODE_RUN     = 3'b100
  } mode_e;

  typedef struct packed {
    logic [CfgW-1:0] short_min;
    logic [CfgW-1:0] long_min;
    logic [CfgW-1:0] long_max;
    logic [CfgW-1:0] hold;
    logic [CfgW-1:0] net_blink;
    logic [CfgW-1:0] dev_blink;
  } cfg_t;

  typedef struct packed {
    logic       save_request;
    logic       release_event;
    logic       status_led;
    logic [2:0] id_display;
    logic [2:0] device_id;
    logic [2:0] network_id;
    logic       edit_field;
    logic [1:0] mode_state;
  } result_t;

endpackage

`default_nettype wire

// ----- src/bpcm_core.sv -----
// ----------------------------------------------------------------------------
// bpcm_core
// Press timer, classifier and menu state; one sample beat per update.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcm_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bpcm_pkg::cfg_t    cfg_i,
  input  wire logic              fire_i,
  input  wire logic              level_i,
  output bpcm_pkg::result_t      result_o
);
  import bpcm_pkg::*;

  logic              last_level_q, last_level_d;
  logic              press_valid_q, press_valid_d;
  logic [TimerW-1:0] press_elapsed_q, press_elapsed_d;
  logic              hold_fired_q, hold_fired_d;
  mode_e             mode_q, mode_d;
  logic              sub_q, sub_d;
  logic [2:0]        net_id_q, net_id_d;
  logic [2:0]        dev_id_q, dev_id_d;
  logic [2:0]        disp_q, disp_d;
  logic [BlinkW-1:0] blink_elapsed_q, blink_elapsed_d;
  logic              blink_level_q, blink_level_d;

  logic [TimerW-1:0] held;
  logic              is_long, is_short, rel_evt, save_req, led;
  logic [CfgW-1:0]   interval;

  always_comb begin
    last_level_d    = last_level_q;
    press_valid_d   = press_valid_q;
    press_elapsed_d = press_elapsed_q;
    hold_fired_d    = hold_fired_q;
    mode_d          = mode_q;
    sub_d           = sub_q;
    net_id_d        = net_id_q;
    dev_id_d        = dev_id_q;
    disp_d          = disp_q;
    rel_evt         = 1'b0;
    save_req        = 1'b0;
    held            = '0;
    is_long         = 1'b0;
    is_short        = 1'b0;

    if (press_valid_q && (press_elapsed_q < TimerMax)) begin
      press_elapsed_d = press_elapsed_q + 1'b1;
    end

    if (!level_i) begin
      if (press_valid_q) begin
        held = press_elapsed_d;
      end
    end else begin
      hold_fired_d = 1'b0;
    end

    if (level_i != last_level_q) begin
      if (level_i) begin
        rel_evt = 1'b1;
        if (press_valid_q) begin
          is_long  = (press_elapsed_d > TimerW'(cfg_i.long_min)) &&
                     (press_elapsed_d < TimerW'(cfg_i.long_max));
          is_short = (press_elapsed_d > TimerW'(cfg_i.short_min)) &&
                     (press_elapsed_d < TimerW'(cfg_i.long_min));
          // long action first, so a short step sees the new field
          if (is_long && (mode_q == MODE_SETTING) && (sub_q == FieldNetwork)) begin
            sub_d = FieldDevice;
          end
          if (is_short && (mode_q == MODE_SETTING)) begin
            if (sub_d == FieldNetwork) begin
              net_id_d = net_id_q + 3'd1;
              disp_d   = net_id_q + 3'd1;
            end else begin
              dev_id_d = dev_id_q + 3'd1;
              disp_d   = dev_id_q + 3'd1;
            end
          end
        end
        press_valid_d = 1'b0;
      end else begin
        press_valid_d = 1'b1;
      end
      press_elapsed_d = '0;
      last_level_d    = level_i;
    end

    if ((held > TimerW'(cfg_i.hold)) && !hold_fired_d) begin
      hold_fired_d = 1'b1;
      unique case (mode_q)
        MODE_SETTING: begin
          mode_d       = MODE_RUN;
          save_req     = 1'b1;
          hold_fired_d = 1'b0;
        end
        MODE_IDLE: begin
          mode_d = MODE_SETTING;
          sub_d  = FieldNetwork;
        end
        MODE_RUN: ;
        default: ;
      endcase
    end
  end

  // blink timer runs in every mode, toggles only in setting mode
  always_comb begin
    blink_elapsed_d = blink_elapsed_q;
    blink_level_d   = blink_level_q;
    interval        = (sub_d == FieldNetwork) ? cfg_i.net_blink : cfg_i.dev_blink;
    if (blink_elapsed_q < BlinkMax) begin
      blink_elapsed_d = blink_elapsed_q + 1'b1;
    end
    led = 1'b0;
    unique case (mode_d)
      MODE_SETTING: begin
        if (blink_elapsed_d >= BlinkW'(interval)) begin
          blink_elapsed_d = '0;
          blink_level_d   = ~blink_level_q;
        end
        led = blink_level_d;
      end
      MODE_RUN:  led = 1'b1;
      MODE_IDLE: led = 1'b0;
      default:   led = 1'b0;
    endcase
  end

  always_comb begin
    result_o.save_request  = save_req;
    result_o.release_event = rel_evt;
    result_o.status_led    = led;
    result_o.id_display    = disp_d;
    result_o.device_id     = dev_id_d;
    result_o.network_id    = net_id_d;
    result_o.edit_field    = sub_d;
    unique case (mode_d)
      MODE_SETTING: result_o.mode_state = ModeCodeSetting;
      MODE_RUN:     result_o.mode_state = ModeCodeRun;
      MODE_IDLE:    result_o.mode_state = ModeCodeIdle;
      default:      result_o.mode_state = ModeCodeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q    <= 1'b0;
      press_valid_q   <= 1'b0;
      press_elapsed_q <= '0;
      hold_fired_q    <= 1'b0;
      mode_q          <= MODE_IDLE;
      sub_q           <= FieldNetwork;
      net_id_q        <= '0;
      dev_id_q        <= '0;
      disp_q          <= '0;
      blink_elapsed_q <= '0;
      blink_level_q   <= 1'b0;
    end else if (fire_i) begin
      last_level_q    <= last_level_d;
      press_valid_q   <= press_valid_d;
      press_elapsed_q <= press_elapsed_d;
      hold_fired_q    <= hold_fired_d;
      mode_q          <= mode_d;
      sub_q           <= sub_d;
      net_id_q        <= net_id_d;
      dev_id_q        <= dev_id_d;
      disp_q          <= disp_d;
      blink_elapsed_q <= blink_elapsed_d;
      blink_level_q   <= blink_level_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/bpcm_skid.sv -----
// ----------------------------------------------------------------------------
// bpcm_skid
// Output register with one skid slot, so the input side keeps moving
// while a result beat waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bpcm_skid (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bpcm_pkg::result_t data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              pop_ready_i,
  output bpcm_pkg::result_t      data_o
);
  import bpcm_pkg::*;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;
  assign pop     = out_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (push_i && (!out_valid_q || pop)) begin
        out_valid_q <= 1'b1;
      end else if (push_i) begin
        skid_valid_q <= 1'b1;
      end else if (pop) begin
        // refill from the skid slot or drain
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= out_valid_q;
        skid_valid_q <= skid_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (push_i && (!out_valid_q || pop)) begin
      out_q <= data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else begin
      out_q  <= out_q;
      skid_q <= skid_q;
    end
  end

endmodule

`default_nettype wire

// ----- src/button_press_classifier_menu_unit.sv -----
// ----------------------------------------------------------------------------
// button_press_classifier_menu_unit
// Each result beat is registered in the output register, or in the skid slot while that holds a beat.
// Throughput: one sample beat per cycle; the menu state updates in a single
// pass of compare and increment logic between the state and output registers.
// The output stage holds two beats, so input stalls only when both are full.
// Reset: asynchronous, active low; restores register defaults and idle state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "button_press_classifier_menu_unit_defines.svh"

module button_press_classifier_menu_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample stream; tdata: [0] button_level, [7:1] zero
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  // result stream; tdata: [1:0] mode_state, [2] edit_field, [5:3] network_id,
  // [8:6] device_id, [11:9] id_display, [12] status_led, [13] release_event,
  // [14] save_request, [15] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,
  // register write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import bpcm_pkg::*;

  cfg_t    cfg_q;
  result_t core_res, out_res;
  logic    fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_min <= ShortMinRst;
      cfg_q.long_min  <= LongMinRst;
      cfg_q.long_max  <= LongMaxRst;
      cfg_q.hold      <= HoldRst;
      cfg_q.net_blink <= NetBlinkRst;
      cfg_q.dev_blink <= DevBlinkRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegShortMin: cfg_q.short_min <= cfg_data_i;
        RegLongMin:  cfg_q.long_min  <= cfg_data_i;
        RegLongMax:  cfg_q.long_max  <= cfg_data_i;
        RegHold:     cfg_q.hold      <= cfg_data_i;
        RegNetBlink: cfg_q.net_blink <= cfg_data_i;
        RegDevBlink: cfg_q.dev_blink <= cfg_data_i;
        // initial id writes are ignored; reset always restores the ids to zero
        RegInitNet:  ;
        RegInitDev:  ;
        default:     ;
      endcase
    end
  end

  assign fire = s_axis_tvalid && s_axis_tready;

  bpcm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .fire_i   (fire),
    .level_i  (s_axis_tdata[0]),
    .result_o (core_res)
  );

  bpcm_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .data_i      (core_res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res};

  `BPCM_ASSERT_NOW(a_stall_has_output, !s_axis_tready, m_axis_tvalid,
                   "input stalled with empty output")
  `BPCM_ASSERT_NOW(a_save_in_run, m_axis_tvalid && out_res.save_request,
                   out_res.mode_state == ModeCodeRun, "save request outside run mode")
  `BPCM_ASSERT_NOW(a_rel_save_excl, m_axis_tvalid,
                   !(out_res.release_event && out_res.save_request),
                   "release and save on one beat")
  `BPCM_ASSERT_NEXT(a_take_fills_out, fire, m_axis_tvalid, "accepted beat left no result")

endmodule

`default_nettype wire

// ----- tb/button_press_classifier_menu_checker.sv -----
// ----------------------------------------------------------------------------
// Button press classifier result checker
// Watches the sample, result and register write ports of the classifier. It
// keeps its own copy of the menu state and the registers, predicts one result
// beat per accepted sample and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module button_press_classifier_menu_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // tdata: [0] button_level, [7:1] zero
  input  logic [bpcm_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: [1:0] mode_state, [2] edit_field, [5:3] network_id, [8:6] device_id,
  // [11:9] id_display, [12] status_led, [13] release_event, [14] save_request
  input  logic [bpcm_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [bpcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpcm_pkg::CfgW-1:0]     cfg_data_i,
  output int unsigned                   errors_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   releases_o,
  output int unsigned                   saves_o
);
  import bpcm_pkg::*;

  localparam int unsigned PrintCap = 30;

  cfg_t              cfg;
  logic [2:0]        cfg_init_net;
  logic [2:0]        cfg_init_dev;

  logic              last_level;
  logic              press_valid;
  logic [TimerW-1:0] press_elapsed;
  logic              hold_fired;
  logic [1:0]        top_mode;
  logic              sub_mode;
  logic [2:0]        net_id;
  logic [2:0]        dev_id;
  logic [2:0]        shown_id;
  logic [BlinkW-1:0] blink_elapsed;
  logic              blink_level;

  result_t           menu_beats[$];

  int unsigned       error_count;
  int unsigned       pending_count;
  int unsigned       checked_count;
  int unsigned       release_count;
  int unsigned       save_count;

  assign errors_o   = error_count;
  assign pending_o  = pending_count;
  assign checked_o  = checked_count;
  assign releases_o = release_count;
  assign saves_o    = save_count;

  initial begin
    error_count   = 0;
    pending_count = 0;
    checked_count = 0;
    release_count = 0;
    save_count    = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    // keep the log short when the block is badly broken
    if (error_count < PrintCap) begin
      $display("[%0t] result beat %0d: %s is %0d, predicted %0d",
               $time, checked_count, what, got, want);
    end
    error_count++;
  endtask

  task automatic compare_field(input string what, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  task automatic load_reset_state();
    cfg.short_min = ShortMinRst;
    cfg.long_min  = LongMinRst;
    cfg.long_max  = LongMaxRst;
    cfg.hold      = HoldRst;
    cfg.net_blink = NetBlinkRst;
    cfg.dev_blink = DevBlinkRst;
    cfg_init_net  = '0;
    cfg_init_dev  = '0;
    last_level    = 1'b0;
    press_valid   = 1'b0;
    press_elapsed = '0;
    hold_fired    = 1'b0;
    top_mode      = ModeCodeIdle;
    sub_mode      = FieldNetwork;
    net_id        = cfg_init_net;
    dev_id        = cfg_init_dev;
    shown_id      = '0;
    blink_elapsed = '0;
    blink_level   = 1'b0;
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    case (idx)
      RegShortMin: cfg.short_min = data;
      RegLongMin:  cfg.long_min  = data;
      RegLongMax:  cfg.long_max  = data;
      RegHold:     cfg.hold      = data;
      RegNetBlink: cfg.net_blink = data;
      RegDevBlink: cfg.dev_blink = data;
      RegInitNet:  cfg_init_net  = data[2:0];
      RegInitDev:  cfg_init_dev  = data[2:0];
    endcase
  endtask

  // Advance the menu by one button sample and return the beat it produces.
  function automatic result_t advance_menu(input logic level);
    result_t           beat;
    logic [TimerW-1:0] held;
    logic [BlinkW-1:0] interval;
    beat = '0;
    held = '0;

    if (press_valid && press_elapsed != TimerMax) begin
      press_elapsed = press_elapsed + 1'b1;
    end
    if (!level) begin
      if (press_valid) begin
        held = press_elapsed;
      end
    end else begin
      hold_fired = 1'b0;
    end

    if (level != last_level) begin
      if (level) begin
        beat.release_event = 1'b1;
        if (press_valid) begin
          // long action first, then short, in case the bounds overlap
          if (press_elapsed > cfg.long_min && press_elapsed < cfg.long_max &&
              top_mode == ModeCodeSetting && sub_mode == FieldNetwork) begin
            sub_mode = FieldDevice;
          end
          if (press_elapsed > cfg.short_min && press_elapsed < cfg.long_min &&
              top_mode == ModeCodeSetting) begin
            if (sub_mode == FieldNetwork) begin
              net_id   = net_id + 3'd1;
              shown_id = net_id;
            end else begin
              dev_id   = dev_id + 3'd1;
              shown_id = dev_id;
            end
          end
        end
        press_valid   = 1'b0;
        press_elapsed = '0;
      end else begin
        press_valid   = 1'b1;
        press_elapsed = '0;
      end
      last_level = level;
    end

    if (held > cfg.hold && !hold_fired) begin
      hold_fired = 1'b1;
      if (top_mode == ModeCodeSetting) begin
        top_mode          = ModeCodeRun;
        beat.save_request = 1'b1;
        hold_fired        = 1'b0;
      end else if (top_mode == ModeCodeIdle) begin
        top_mode = ModeCodeSetting;
        sub_mode = FieldNetwork;
      end
    end

    if (blink_elapsed != BlinkMax) begin
      blink_elapsed = blink_elapsed + 1'b1;
    end
    if (top_mode == ModeCodeSetting) begin
      interval = (sub_mode == FieldNetwork) ? cfg.net_blink : cfg.dev_blink;
      if (blink_elapsed >= interval) begin
        blink_elapsed = '0;
        blink_level   = ~blink_level;
      end
      beat.status_led = blink_level;
    end else begin
      beat.status_led = (top_mode == ModeCodeRun);
    end

    beat.mode_state = top_mode;
    beat.edit_field = sub_mode;
    beat.network_id = net_id;
    beat.device_id  = dev_id;
    beat.id_display = shown_id;
    return beat;
  endfunction

  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      load_reset_state();
      menu_beats.delete();
    end else begin
      if (cfg_we_i) begin
        write_register(cfg_idx_i, cfg_data_i);
      end
      // retire the result beat before queuing a new prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (menu_beats.size() == 0) begin
          report_mismatch("unexpected beat, tdata", m_axis_tdata, 0);
        end else begin
          want = menu_beats.pop_front();
          seen = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
          compare_field("mode_state",    seen.mode_state,    want.mode_state);
          compare_field("edit_field",    seen.edit_field,    want.edit_field);
          compare_field("network_id",    seen.network_id,    want.network_id);
          compare_field("device_id",     seen.device_id,     want.device_id);
          compare_field("id_display",    seen.id_display,    want.id_display);
          compare_field("status_led",    seen.status_led,    want.status_led);
          compare_field("release_event", seen.release_event, want.release_event);
          compare_field("save_request",  seen.save_request,  want.save_request);
          compare_field("tdata pad bit", m_axis_tdata[OutDataW-1], 0);
          if (want.release_event) release_count++;
          if (want.save_request) save_count++;
        end
        checked_count++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        menu_beats.push_back(advance_menu(s_axis_tdata[0]));
      end
    end
    pending_count <= menu_beats.size();
  end

endmodule

// ----- tb/button_press_classifier_menu_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Button press classifier testbench
// Drives button sample beats shaped as presses of chosen lengths around the
// register bounds, under several register settings and throttling phases on
// both streams. A checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module button_press_classifier_menu_unit_tb;
  import bpcm_pkg::*;

  localparam int unsigned QuietLimit   = 1000;
  localparam int unsigned PhaseSamples = 220;
  localparam int unsigned NumPhases    = 4;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned releases;
  int unsigned saves;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned samples_sent;
  int unsigned settings_written;

  // bounds currently in the block, used to shape press lengths
  int unsigned thr_short;
  int unsigned thr_long_min;
  int unsigned thr_long_max;
  int unsigned thr_hold;

  button_press_classifier_menu_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  button_press_classifier_menu_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked),
    .releases_o    (releases),
    .saves_o       (saves)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: stall at the phase's rate
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
             QuietLimit, pending);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_sample(input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-1){1'b0}}, level};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    samples_sent++;
  endtask

  // len pressed samples give a press length of len at the release
  task automatic press_button(input int unsigned len);
    repeat (len) send_sample(1'b0);
    repeat ($urandom_range(3, 1)) send_sample(1'b1);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_settings(input int unsigned short_min, input int unsigned long_min,
                                input int unsigned long_max, input int unsigned hold,
                                input int unsigned net_blink, input int unsigned dev_blink,
                                input int unsigned init_net, input int unsigned init_dev);
    logic [CfgW-1:0] vals [8];
    vals[RegShortMin] = CfgW'(short_min);
    vals[RegLongMin]  = CfgW'(long_min);
    vals[RegLongMax]  = CfgW'(long_max);
    vals[RegHold]     = CfgW'(hold);
    vals[RegNetBlink] = CfgW'(net_blink);
    vals[RegDevBlink] = CfgW'(dev_blink);
    vals[RegInitNet]  = CfgW'(init_net % 8);
    vals[RegInitDev]  = CfgW'(init_dev % 8);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i     <= 1'b0;
    thr_short    = short_min;
    thr_long_min = long_min;
    thr_long_max = long_max;
    thr_hold     = hold;
    settings_written++;
  endtask

  task automatic write_random_settings();
    int unsigned s_min;
    int unsigned l_min;
    int unsigned l_max;
    s_min = $urandom_range(4);
    // now and then invert the short bounds so no short press exists
    l_min = ($urandom_range(6) == 0) ? $urandom_range(s_min) : s_min + $urandom_range(6, 1);
    l_max = l_min + $urandom_range(8, 1);
    write_settings(s_min, l_min, l_max, l_max + $urandom_range(40, 20),
                   $urandom_range(15), $urandom_range(15),
                   $urandom_range(7), $urandom_range(7));
  endtask

  function automatic int unsigned pick_press_len(input bit allow_long, input bit allow_hold);
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    int unsigned bounds [7];
    pick = $urandom_range(99);
    if (allow_hold && pick < 6) begin
      return thr_hold + $urandom_range(3, 1);
    end
    if (pick < 20) begin
      bounds = '{thr_short, thr_short + 1,
                 (thr_long_min == 0) ? 0 : thr_long_min - 1, thr_long_min, thr_long_min + 1,
                 (thr_long_max == 0) ? 0 : thr_long_max - 1, thr_long_max};
      return bounds[$urandom_range(6)];
    end
    if (allow_long && pick < 32) begin
      lo = thr_long_min + 1;
      hi = (thr_long_max == 0) ? 0 : thr_long_max - 1;
    end else if (pick < 45) begin
      lo = 0;
      hi = thr_long_max + 3;
    end else begin
      lo = thr_short + 1;
      hi = (thr_long_min == 0) ? 0 : thr_long_min - 1;
    end
    return (lo <= hi) ? $urandom_range(hi, lo) : lo;
  endfunction

  initial begin
    int unsigned phase_start;
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    samples_sent     = 0;
    settings_written = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: tiny bounds, network blink interval of zero.
    write_settings(1, 3, 5, 6, 0, 2, 0, 0);
    // press held from reset is never timed, then a release with no timed press
    repeat (3) send_sample(1'b0);
    send_sample(1'b1);
    press_button(1);   // at the short lower bound: no action
    press_button(2);   // short press while idle: no step
    press_button(4);   // long press while idle: no field change
    press_button(8);   // hold fires: idle to setting
    press_button(2);   // short press steps the network id

    for (int p = 0; p < NumPhases; p++) begin
      wait_for_results();
      write_random_settings();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      phase_start = samples_sent;
      while (samples_sent - phase_start < PhaseSamples) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(6, 1)) send_sample(1'($urandom_range(1)));
        end else begin
          // network stepping first; the device field and run mode come later
          press_button(pick_press_len(p > 0, p == NumPhases - 1));
        end
        if ($urandom_range(39) == 0) begin
          wait_for_results();
        end
      end
    end

    // Long and hold bounds and blink intervals at the top of their range, short bound at zero, then one press.
    wait_for_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_settings(0, int'(TimerMax), int'(TimerMax), int'(TimerMax),
                   int'(BlinkMax), int'(BlinkMax), 7, 7);
    press_button(40);

    wait_for_results();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d sample beats under %0d register settings and four throttling phases,",
             samples_sent, settings_written);
    $display("checked %0d result beats with %0d release events and %0d save requests.",
             checked, releases, saves);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
